// ----- rtl/tkds_pkg.sv -----
// Shared types and constants for the top-k distinct sorter.
`default_nettype none
package tkds_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int VALUE_W         = 32;
  localparam int KEEP_W          = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic signed [VALUE_W-1:0] value;
  } q_item_t;

endpackage
`default_nettype wire

// ----- rtl/tkds_front.sv -----
// Front end: accepts input transactions into a two-entry queue.
`default_nettype none
module tkds_front
  import tkds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [VALUE_W-1:0] s_tdata,   // sample_value
  input  wire logic               s_tuser,   // opcode
  output logic                    q_valid,
  input  wire logic               q_ready,
  output q_item_t                 q_item
);

  q_item_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign s_tready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].opcode <= s_tuser;
      slots[wr_ptr].value  <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tkds_back.sv -----
// Back end: compare-and-shift cells, keep limit register and readout sequencer.
`default_nettype none
module tkds_back
  import tkds_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire q_item_t            q_item,
  input  wire logic               cfg_we,
  input  wire logic [KEEP_W-1:0]  cfg_wdata,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [VALUE_W-1:0]      m_tdata,
  output logic                    m_tlast,
  output logic                    m_tuser
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_EMPTY = 3'b100
  } state_t;

  state_t                    state, state_next;
  logic signed [VALUE_W-1:0] cells      [MAX_ENTRIES];
  logic signed [VALUE_W-1:0] cells_next [MAX_ENTRIES];
  logic [CW-1:0]             count, count_next;
  logic [KEEP_W-1:0]         keep_limit;
  logic [CW-1:0]             eff_lim;
  logic [CW-1:0]             cfg_lim;
  logic [MAX_ENTRIES-1:0]    vld, gt, eq, keep;
  logic                      dup, all_gt, drop, pop, taken;

  function automatic logic [CW-1:0] eff_of(input logic [KEEP_W-1:0] kl);
    logic [CW-1:0] r;
    if (kl == '0) r = CW'(1);
    else if (32'(kl) > MAX_ENTRIES) r = CW'(MAX_ENTRIES);
    else r = CW'(kl);
    return r;
  endfunction

  assign eff_lim = eff_of(keep_limit);
  assign cfg_lim = eff_of(cfg_wdata);
  assign q_ready = (state == ST_IDLE);
  assign pop     = q_valid && q_ready;
  assign taken   = m_tvalid && m_tready;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      vld[i]  = CW'(i) < count;
      gt[i]   = cells[i] > q_item.value;
      eq[i]   = cells[i] == q_item.value;
      keep[i] = gt[i] && vld[i];
    end
    dup    = |(eq & vld);
    all_gt = &(gt | ~vld);
    drop   = dup || ((count == eff_lim) && all_gt);
  end

  always_comb begin
    state_next = state;
    count_next = count;
    for (int i = 0; i < MAX_ENTRIES; i++) cells_next[i] = cells[i];
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          if (q_item.opcode == OP_READOUT) begin
            state_next = (count == '0) ? ST_EMPTY : ST_READ;
          end else if (!drop) begin
            cells_next[0] = keep[0] ? cells[0] : q_item.value;
            for (int i = 1; i < MAX_ENTRIES; i++) begin
              if (keep[i]) cells_next[i] = cells[i];
              else if (keep[i-1]) cells_next[i] = q_item.value;
              else cells_next[i] = cells[i-1];
            end
            if (count < eff_lim) count_next = count + CW'(1);
          end
        end
      end
      ST_READ: begin
        if (taken) begin
          for (int i = 0; i < MAX_ENTRIES - 1; i++) cells_next[i] = cells[i+1];
          count_next = count - CW'(1);
          if (count == CW'(1)) state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (taken) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (cfg_we && (count_next > cfg_lim)) count_next = cfg_lim;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) cells[i] <= cells_next[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      keep_limit <= KEEP_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) keep_limit <= cfg_wdata;
    end
  end

  assign m_tvalid = (state == ST_READ) || (state == ST_EMPTY);
  assign m_tdata  = (state == ST_READ) ? cells[0] : '0;
  assign m_tlast  = (state == ST_EMPTY) || (count == CW'(1));
  assign m_tuser  = (state == ST_EMPTY);

  a_count_in_limit: assert property (@(posedge clk) disable iff (rst)
    count <= eff_lim) else $error("entry count above limit");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (count != '0)) else $error("readout with no entries");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (taken && m_tlast) |=> (state == ST_IDLE && count == '0))
    else $error("readout did not end on last");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (cells[0] > cells[(MAX_ENTRIES > 1) ? 1 : 0]))
    else $error("head entries out of order");

endmodule
`default_nettype wire

// ----- rtl/top_k_distinct_sorter_unit.sv -----
// Top level of the top-k distinct sorter.
// A transaction is registered in the two-entry input queue, then the back end
// takes it when idle; an insert is written into the compare-and-shift cells.
// One insert per cycle while the back end is idle; a readout holds the back end
// until its last result, one result per ready cycle (n values, 1 if empty).
// Reset (synchronous, rst high): queue emptied, entry count zero, keep limit 16.
`default_nettype none
module top_k_distinct_sorter_unit
  import tkds_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [VALUE_W-1:0] s_tdata,   // sample_value
  input  wire logic               s_tuser,   // opcode
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [VALUE_W-1:0]      m_tdata,   // kept_value
  output logic                    m_tlast,   // is_last
  output logic                    m_tuser,   // list_empty
  input  wire logic               cfg_we,
  input  wire logic [KEEP_W-1:0]  cfg_wdata
);

  logic    q_valid;
  logic    q_ready;
  q_item_t q_item;

  tkds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  tkds_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the top-k distinct sorter unit.
`timescale 1ns / 1ps
module testbench
  import tkds_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [VALUE_W-1:0] kept;
    logic               last;
    logic               empty;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;
  logic               s_tuser = OP_INSERT;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [VALUE_W-1:0] m_tdata;
  logic               m_tlast;
  logic               m_tuser;
  logic               cfg_we = 1'b0;
  logic [KEEP_W-1:0]  cfg_wdata = '0;

  logic               no_idle = 1'b0;
  int                 error_count = 0;
  int                 quiet_cycles = 0;

  // predicted sorter state
  logic signed [VALUE_W-1:0] held_values [DEF_MAX_ENTRIES];
  int unsigned               held_count = 0;
  logic [KEEP_W-1:0]         keep_setting = KEEP_RESET;
  result_t                   pending_results [$];

  top_k_distinct_sorter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned effective_limit();
    if (keep_setting == 0) return 1;
    if (keep_setting > DEF_MAX_ENTRIES) return DEF_MAX_ENTRIES;
    return 32'(keep_setting);
  endfunction

  function automatic void topk_insert(input logic signed [VALUE_W-1:0] v);
    int unsigned lim;
    int unsigned pos;
    int unsigned tail;
    lim = effective_limit();
    if (held_count > lim) held_count = lim;
    pos = 0;
    while (pos < held_count && held_values[pos] > v) pos++;
    if (pos < held_count && held_values[pos] == v) return;
    if (pos >= lim) return;
    tail = (held_count < lim - 1) ? held_count : lim - 1;
    for (int unsigned i = tail; i > pos; i--) held_values[i] = held_values[i-1];
    held_values[pos] = v;
    if (held_count < lim) held_count++;
  endfunction

  function automatic void topk_readout();
    result_t r;
    if (held_count == 0) begin
      r.kept  = '0;
      r.last  = 1'b1;
      r.empty = 1'b1;
      pending_results.push_back(r);
      return;
    end
    for (int unsigned i = 0; i < held_count; i++) begin
      r.kept  = held_values[i];
      r.last  = (i + 1 == held_count);
      r.empty = 1'b0;
      pending_results.push_back(r);
    end
    held_count = 0;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", m_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.kept) report_mismatch("kept_value", m_tdata, want.kept);
        if (m_tlast !== want.last) begin
          report_mismatch("is_last", VALUE_W'(m_tlast), VALUE_W'(want.last));
        end
        if (m_tuser !== want.empty) begin
          report_mismatch("list_empty", VALUE_W'(m_tuser), VALUE_W'(want.empty));
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [VALUE_W-1:0] v);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while (gap < 12 && $urandom_range(99) < 28) gap++;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_INSERT) topk_insert(v);
    else topk_readout();
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [KEEP_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_setting = v;
    if (held_count > effective_limit()) held_count = effective_limit();
  endtask

  function automatic logic [VALUE_W-1:0] random_sample();
    case ($urandom_range(3))
      0: return $urandom_range(15) - 8;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_readout();
    send_item(OP_READOUT, '0);
  endtask

  task automatic test_value_extremes();
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hffff_ffff);
    send_item(OP_INSERT, 32'h0000_0001);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_READOUT, 32'hffff_ffff);
  endtask

  task automatic test_zero_limit();
    wait_for_drain();
    write_limit(5'd0);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_INSERT, 32'd9);
    send_item(OP_INSERT, 32'd2);
    send_item(OP_READOUT, '0);
  endtask

  task automatic test_full_list();
    wait_for_drain();
    write_limit(5'd3);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_INSERT, 32'd9);
    send_item(OP_INSERT, 32'd1);
    send_item(OP_INSERT, 32'd0);
    send_item(OP_INSERT, 32'd7);
    send_item(OP_READOUT, '0);
  endtask

  task automatic test_limit_lowered();
    wait_for_drain();
    write_limit(5'd16);
    for (int i = 0; i < 6; i++) send_item(OP_INSERT, 32'd100 - 32'(i * 7));
    wait_for_drain();
    write_limit(5'd2);
    send_item(OP_READOUT, '0);
  endtask

  task automatic test_random_phases();
    logic [KEEP_W-1:0] limits [7] = '{5'd0, 5'd1, 5'd15, 5'd16, 5'd17, 5'd31, 5'd4};
    for (int phase = 0; phase < 12; phase++) begin
      wait_for_drain();
      if (phase < 7) write_limit(limits[phase]);
      else write_limit(KEEP_W'($urandom));
      for (int n = 0; n < 36; n++) begin
        if ($urandom_range(99) < 10) send_item(OP_READOUT, $urandom);
        else send_item(OP_INSERT, random_sample());
      end
    end
  endtask

  task automatic test_back_to_back();
    wait_for_drain();
    write_limit(5'd31);
    no_idle = 1'b1;
    for (int n = 0; n < 60; n++) begin
      if (n % 20 == 19) send_item(OP_READOUT, '0);
      else send_item(OP_INSERT, random_sample());
    end
    wait_for_drain();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_readout();
    test_value_extremes();
    test_zero_limit();
    test_full_list();
    test_limit_lowered();
    test_random_phases();
    test_back_to_back();
    wait_for_drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tkds_pkg.sv
rtl/tkds_front.sv
rtl/tkds_back.sv
rtl/top_k_distinct_sorter_unit.sv
test/testbench.sv
